FILE: hdl/cc3p_pkg.sv
package cc3p_pkg;

  localparam int CC3P_COORD_WIDTH = 32;
  localparam int CC3P_FRAC_BITS   = 16;

  // register index (byte address bit 2)
  localparam logic CC3P_REG_THRESHOLD = 1'b0;

  // per-coordinate control traveling with the data
  typedef struct packed {
    logic vld;
    logic degen;
    logic neg;
    logic big;
  } item_t;

endpackage

FILE: hdl/cc3p_front.sv
module cc3p_front import cc3p_pkg::*; #(
  parameter int W = CC3P_COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [6*W-1:0]      pts,
  input  logic [31:0]         thr,
  output item_t               itx,
  output item_t               ity,
  output logic [3*W+3:0]      tmagx,
  output logic [3*W+3:0]      tmagy,
  output logic [2*W+2:0]      d2,
  output logic [W-1:0]        bx,
  output logic [W-1:0]        by
);

  localparam int DW   = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int AW   = 2 * W + 2;
  localparam int DETW = 2 * W + 3;
  localparam int PPW  = 2 * W + 3;
  localparam int NW   = 3 * W + 4;
  localparam int RW   = NW + 1;
  localparam int MW   = (DETW > 32) ? DETW : 32;

  logic signed [W-1:0] x1, y1, x2, y2, x3, y3;
  assign x1 = $signed(pts[W-1:0]);
  assign y1 = $signed(pts[2*W-1:W]);
  assign x2 = $signed(pts[3*W-1:2*W]);
  assign y2 = $signed(pts[4*W-1:3*W]);
  assign x3 = $signed(pts[5*W-1:4*W]);
  assign y3 = $signed(pts[6*W-1:5*W]);

  logic [9:1]   vp;
  logic [W-1:0] bxp [1:9];
  logic [W-1:0] byp [1:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[8:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bxp[1] <= pts[W-1:0];
      byp[1] <= pts[2*W-1:W];
      for (int i = 2; i <= 9; i++) begin
        bxp[i] <= bxp[i-1];
        byp[i] <= byp[i-1];
      end
    end
  end

  // stage 1: edge differences
  logic signed [DW-1:0] d11_1, d12_1, d21_1, d22_1;
  always_ff @(posedge clk) begin
    if (en) begin
      d11_1 <= DW'(x2) - DW'(x1);
      d12_1 <= DW'(y2) - DW'(y1);
      d21_1 <= DW'(x3) - DW'(x1);
      d22_1 <= DW'(y3) - DW'(y1);
    end
  end

  // stage 2: squares and cross products
  logic signed [DW-1:0] d11_2, d12_2, d21_2, d22_2;
  logic signed [PW-1:0] sq11_2, sq12_2, sq21_2, sq22_2, m1_2, m2_2;
  always_ff @(posedge clk) begin
    if (en) begin
      d11_2  <= d11_1;
      d12_2  <= d12_1;
      d21_2  <= d21_1;
      d22_2  <= d22_1;
      sq11_2 <= d11_1 * d11_1;
      sq12_2 <= d12_1 * d12_1;
      sq21_2 <= d21_1 * d21_1;
      sq22_2 <= d22_1 * d22_1;
      m1_2   <= d11_1 * d22_1;
      m2_2   <= d21_1 * d12_1;
    end
  end

  // stage 3: squared lengths, determinant
  logic signed [DW-1:0]   d11_3, d12_3, d21_3, d22_3;
  logic [AW-1:0]          a1_3, a2_3;
  logic signed [DETW-1:0] det_3;
  always_ff @(posedge clk) begin
    if (en) begin
      d11_3 <= d11_2;
      d12_3 <= d12_2;
      d21_3 <= d21_2;
      d22_3 <= d22_2;
      a1_3  <= sq11_2 + sq12_2;
      a2_3  <= sq21_2 + sq22_2;
      det_3 <= DETW'(m1_2) - DETW'(m2_2);
    end
  end

  // stage 4: |det|, collinear test, partial products (A split in halves)
  logic [DETW-1:0]       adet_4;
  logic                  degen_4, ndet_4;
  logic signed [PPW-1:0] p1l_4, p1h_4, p2l_4, p2h_4, p3l_4, p3h_4, p4l_4, p4h_4;
  logic [DETW-1:0]       adet_c;
  assign adet_c = det_3[DETW-1] ? -det_3 : det_3;

  always_ff @(posedge clk) begin
    if (en) begin
      adet_4  <= adet_c;
      ndet_4  <= det_3[DETW-1];
      degen_4 <= (adet_c == '0) || (MW'(adet_c) < MW'(thr));
      p1l_4   <= $signed({1'b0, a1_3[W:0]}) * d22_3;
      p1h_4   <= $signed({1'b0, a1_3[AW-1:W+1]}) * d22_3;
      p2l_4   <= $signed({1'b0, a2_3[W:0]}) * d12_3;
      p2h_4   <= $signed({1'b0, a2_3[AW-1:W+1]}) * d12_3;
      p3l_4   <= $signed({1'b0, a2_3[W:0]}) * d11_3;
      p3h_4   <= $signed({1'b0, a2_3[AW-1:W+1]}) * d11_3;
      p4l_4   <= $signed({1'b0, a1_3[W:0]}) * d21_3;
      p4h_4   <= $signed({1'b0, a1_3[AW-1:W+1]}) * d21_3;
    end
  end

  // stage 5: full products
  logic signed [NW-1:0] pr1_5, pr2_5, pr3_5, pr4_5;
  logic [DETW-1:0]      adet_5, d2_5;
  logic                 degen_5, ndet_5;
  always_ff @(posedge clk) begin
    if (en) begin
      pr1_5   <= (NW'(p1h_4) <<< (W + 1)) + NW'(p1l_4);
      pr2_5   <= (NW'(p2h_4) <<< (W + 1)) + NW'(p2l_4);
      pr3_5   <= (NW'(p3h_4) <<< (W + 1)) + NW'(p3l_4);
      pr4_5   <= (NW'(p4h_4) <<< (W + 1)) + NW'(p4l_4);
      adet_5  <= adet_4;
      d2_5    <= {adet_4[DETW-2:0], 1'b0};
      degen_5 <= degen_4;
      ndet_5  <= ndet_4;
    end
  end

  // stage 6: numerators, sign folded so the divisor is positive
  logic signed [NW-1:0] nx_6, ny_6;
  logic [DETW-1:0]      adet_6, d2_6;
  logic                 degen_6;
  always_ff @(posedge clk) begin
    if (en) begin
      nx_6    <= ndet_5 ? (pr2_5 - pr1_5) : (pr1_5 - pr2_5);
      ny_6    <= ndet_5 ? (pr4_5 - pr3_5) : (pr3_5 - pr4_5);
      adet_6  <= adet_5;
      d2_6    <= d2_5;
      degen_6 <= degen_5;
    end
  end

  // stage 7: add det for round-to-nearest
  logic signed [NW-1:0] tx_7, ty_7;
  logic [DETW-1:0]      d2_7;
  logic                 degen_7;
  always_ff @(posedge clk) begin
    if (en) begin
      tx_7    <= nx_6 + $signed(NW'(adet_6));
      ty_7    <= ny_6 + $signed(NW'(adet_6));
      d2_7    <= d2_6;
      degen_7 <= degen_6;
    end
  end

  // stage 8: sign and magnitude
  logic [NW-1:0]   tmx_8, tmy_8;
  logic            negx_8, negy_8, degen_8;
  logic [DETW-1:0] d2_8;
  always_ff @(posedge clk) begin
    if (en) begin
      negx_8  <= tx_7[NW-1];
      negy_8  <= ty_7[NW-1];
      tmx_8   <= tx_7[NW-1] ? -tx_7 : tx_7;
      tmy_8   <= ty_7[NW-1] ? -ty_7 : ty_7;
      d2_8    <= d2_7;
      degen_8 <= degen_7;
    end
  end

  // stage 9: quotient too large for the divider range
  logic [NW-1:0]   tmx_9, tmy_9;
  logic            negx_9, negy_9, degen_9, bigx_9, bigy_9;
  logic [DETW-1:0] d2_9;
  logic [RW-1:0]   dlim;
  assign dlim = RW'(d2_8) << (W + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      tmx_9   <= tmx_8;
      tmy_9   <= tmy_8;
      negx_9  <= negx_8;
      negy_9  <= negy_8;
      bigx_9  <= RW'(tmx_8) >= dlim;
      bigy_9  <= RW'(tmy_8) >= dlim;
      d2_9    <= d2_8;
      degen_9 <= degen_8;
    end
  end

  assign itx   = '{vld: vp[9], degen: degen_9, neg: negx_9, big: bigx_9};
  assign ity   = '{vld: vp[9], degen: degen_9, neg: negy_9, big: bigy_9};
  assign tmagx = tmx_9;
  assign tmagy = tmy_9;
  assign d2    = d2_9;
  assign bx    = bxp[9];
  assign by    = byp[9];

endmodule

FILE: hdl/cc3p_div.sv
module cc3p_div import cc3p_pkg::*; #(
  parameter int W = CC3P_COORD_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  item_t           it_in,
  input  logic [3*W+3:0]  tmag,
  input  logic [2*W+2:0]  d2,
  input  logic [W-1:0]    base,
  output item_t           it_out,
  output logic [W:0]      quo,
  output logic            rem_nz,
  output logic [W-1:0]    base_out
);

  localparam int NW  = 3 * W + 4;
  localparam int RW  = NW + 1;
  localparam int D2W = 2 * W + 3;

  item_t          its [0:W];
  logic [RW-1:0]  rs  [0:W];
  logic [D2W-1:0] ds  [0:W];
  logic [W:0]     qs  [0:W];
  logic [W-1:0]   bs  [0:W];

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i <= W; i++) begin : g_stage
    localparam int K = W - i;
    item_t          it_i;
    logic [RW-1:0]  r_i, sub;
    logic [D2W-1:0] d_i;
    logic [W:0]     q_i;
    logic [W-1:0]   b_i;
    logic           ge;

    if (i == 0) begin : g_first
      assign it_i = it_in;
      assign r_i  = RW'(tmag);
      assign d_i  = d2;
      assign q_i  = '0;
      assign b_i  = base;
    end else begin : g_next
      assign it_i = its[i-1];
      assign r_i  = rs[i-1];
      assign d_i  = ds[i-1];
      assign q_i  = qs[i-1];
      assign b_i  = bs[i-1];
    end

    assign sub = RW'(d_i) << K;
    assign ge  = r_i >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        its[i] <= '0;
      end else if (en) begin
        its[i] <= it_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rs[i] <= ge ? (r_i - sub) : r_i;
        qs[i] <= {q_i[W-1:0], ge};
        ds[i] <= d_i;
        bs[i] <= b_i;
      end
    end
  end

  assign it_out   = its[W];
  assign quo      = qs[W];
  assign rem_nz   = |rs[W];
  assign base_out = bs[W];

endmodule

FILE: hdl/cc3p_round.sv
module cc3p_round import cc3p_pkg::*; #(
  parameter int W = CC3P_COORD_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  item_t        it_in,
  input  logic [W:0]   quo,
  input  logic         rem_nz,
  input  logic [W-1:0] base,
  output item_t        it_out,
  output logic [W-1:0] center,
  output logic         ovf
);

  localparam int QSW = W + 3;
  localparam logic signed [QSW-1:0] MAXV = {{4{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [QSW-1:0] MINV = {{4{1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXO = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINO = {1'b1, {(W-1){1'b0}}};

  item_t                 it1;
  logic signed [QSW-1:0] qs1;
  logic [W-1:0]          b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      it1 <= '0;
    end else if (en) begin
      it1 <= it_in;
    end
  end

  // negative side: floor of the signed quotient
  always_ff @(posedge clk) begin
    if (en) begin
      qs1 <= it_in.neg ? -(QSW'(quo) + QSW'(rem_nz)) : QSW'(quo);
      b1  <= base;
    end
  end

  logic signed [QSW-1:0] sum;
  assign sum = qs1 + QSW'($signed(b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      it_out <= '0;
    end else if (en) begin
      it_out <= it1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (it1.degen) begin
        center <= MAXO;
        ovf    <= 1'b0;
      end else if (it1.big) begin
        center <= it1.neg ? MINO : MAXO;
        ovf    <= 1'b1;
      end else if (sum > MAXV) begin
        center <= MAXO;
        ovf    <= 1'b1;
      end else if (sum < MINV) begin
        center <= MINO;
        ovf    <= 1'b1;
      end else begin
        center <= sum[W-1:0];
        ovf    <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/circle_center_three_points.sv
// Circumcenter of three points, signed fixed point (Q16.16 by default).
// Input stream s_*: one triangle per transfer, s_tdata holds
//   first_x, first_y, second_x, second_y, third_x, third_y from bit 0 up.
// Output stream m_*: one result per input, m_tdata holds center_x, center_y;
//   m_tuser[0] = degenerate, m_tuser[1] = overflow.
// Config: APB register det_threshold at address 0 (|det| limit, 2^-2F units).
// Pipeline: 9 front stages (differences, products, numerators), one
//   restoring-division stage per quotient bit, 2 rounding/saturation
//   stages.
// One transfer per cycle unless the output stalls; all stages move together.
// When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; empty slots still advance while the output is empty.
// Reset clears all valid bits and loads det_threshold with round(1e-5 * 2^2F).
// Collinear points give degenerate = 1 and both centers at the most
//   positive value; centers out of range saturate and set overflow.
module circle_center_three_points import cc3p_pkg::*; #(
  parameter int COORD_WIDTH = CC3P_COORD_WIDTH,
  parameter int FRAC_BITS   = CC3P_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // center_x, center_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
  // degenerate, overflow
  output logic [1:0]                              m_tuser,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int W   = COORD_WIDTH;
  localparam int TOW = ((2 * W + 7) / 8) * 8;
  localparam longint unsigned FULL = 64'd1 << (2 * FRAC_BITS);
  localparam logic [31:0] THR_RST = 32'((FULL + 64'd50000) / 64'd100000);

  logic [31:0] det_threshold;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == CC3P_REG_THRESHOLD) begin
      det_threshold <= pwdata;
    end
  end

  assign prdata = (paddr[2] == CC3P_REG_THRESHOLD) ? det_threshold : '0;

  item_t          itx_f, ity_f, itx_d, ity_d, itx_r, ity_r;
  logic [3*W+3:0] tmagx, tmagy;
  logic [2*W+2:0] d2;
  logic [W-1:0]   bx_f, by_f, bx_d, by_d, cx, cy;
  logic [W:0]     qx, qy;
  logic           rnx, rny, ovx, ovy, en;

  assign en       = !itx_r.vld || m_tready;
  assign s_tready = en;

  cc3p_front #(.W(W)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid),
    .pts    (s_tdata[6*W-1:0]),
    .thr    (det_threshold),
    .itx    (itx_f),
    .ity    (ity_f),
    .tmagx  (tmagx),
    .tmagy  (tmagy),
    .d2     (d2),
    .bx     (bx_f),
    .by     (by_f)
  );

  cc3p_div #(.W(W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .it_in    (itx_f),
    .tmag     (tmagx),
    .d2       (d2),
    .base     (bx_f),
    .it_out   (itx_d),
    .quo      (qx),
    .rem_nz   (rnx),
    .base_out (bx_d)
  );

  cc3p_div #(.W(W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .it_in    (ity_f),
    .tmag     (tmagy),
    .d2       (d2),
    .base     (by_f),
    .it_out   (ity_d),
    .quo      (qy),
    .rem_nz   (rny),
    .base_out (by_d)
  );

  cc3p_round #(.W(W)) u_round_x (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .it_in  (itx_d),
    .quo    (qx),
    .rem_nz (rnx),
    .base   (bx_d),
    .it_out (itx_r),
    .center (cx),
    .ovf    (ovx)
  );

  cc3p_round #(.W(W)) u_round_y (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .it_in  (ity_d),
    .quo    (qy),
    .rem_nz (rny),
    .base   (by_d),
    .it_out (ity_r),
    .center (cy),
    .ovf    (ovy)
  );

  assign m_tvalid = itx_r.vld;
  assign m_tdata  = TOW'({cy, cx});
  assign m_tuser  = {ovx || ovy, itx_r.degen};

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    itx_r.vld == ity_r.vld && itx_r.degen == ity_r.degen)
    else $error("x and y lanes out of step");

  a_degen_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("degenerate result flagged as overflow");

  a_degen_sentinel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> cx == {1'b0, {(W-1){1'b1}}} &&
                               cy == {1'b0, {(W-1){1'b1}}})
    else $error("degenerate result without sentinel center");

endmodule
